FILE: src/nclfsr_pkg.sv
// ----------------------------------------------------------------------------
// nclfsr_pkg
// Shared types and constants for the noise voice: register indexes,
// item kinds and the configuration bundle.
// ----------------------------------------------------------------------------
package nclfsr_pkg;

  localparam int unsigned SrW       = 15;
  localparam int unsigned PeriodW   = 12;
  localparam int unsigned LenW      = 8;
  localparam int unsigned LevelW    = 4;
  localparam int unsigned DivW      = 5;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 8;

  localparam logic [SrW-1:0]     SrReset     = 15'h0001;
  localparam logic [SrW-2:0]     FbKeep      = 14'h3FFF;
  localparam logic [LevelW-1:0]  LevelMax    = 4'hF;
  localparam logic [PeriodW-1:0] PeriodReset = 12'd4;

  // item kinds
  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_ENV_CLK  = 2'd1,
    FUNC_LEN_CLK  = 2'd2,
    FUNC_LEN_LOAD = 2'd3
  } func_t;

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_SHORT_MODE      = 3'd0,
    REG_TIMER_PERIOD    = 3'd1,
    REG_HALT_REQUEST    = 3'd2,
    REG_CONSTANT_VOLUME = 3'd3,
    REG_VOLUME_OR_DECAY = 3'd4,
    REG_CHANNEL_ENABLED = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic               short_mode;
    logic [PeriodW-1:0] timer_period;
    logic               halt_request;
    logic               constant_volume;
    logic [LevelW-1:0]  volume_or_decay;
    logic               channel_enabled;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] sample;
    logic              sample_strobe;
    logic              length_active;
  } result_t;

endpackage

FILE: src/nclfsr_cfg.sv
// ----------------------------------------------------------------------------
// nclfsr_cfg
// Configuration register file, write-only, one register per index.
// ----------------------------------------------------------------------------
module nclfsr_cfg
  import nclfsr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_SHORT_MODE:      cfg_nxt.short_mode      = cfg_wdata[0];
        REG_TIMER_PERIOD:    cfg_nxt.timer_period    = cfg_wdata[PeriodW-1:0];
        REG_HALT_REQUEST:    cfg_nxt.halt_request    = cfg_wdata[0];
        REG_CONSTANT_VOLUME: cfg_nxt.constant_volume = cfg_wdata[0];
        REG_VOLUME_OR_DECAY: cfg_nxt.volume_or_decay = cfg_wdata[LevelW-1:0];
        REG_CHANNEL_ENABLED: cfg_nxt.channel_enabled = cfg_wdata[0];
        default: ; // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{short_mode:      1'b0,
                 timer_period:    PeriodReset,
                 halt_request:    1'b0,
                 constant_volume: 1'b0,
                 volume_or_decay: {LevelW{1'b0}},
                 channel_enabled: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: src/nclfsr_core.sv
// ----------------------------------------------------------------------------
// nclfsr_core
// Voice state (shift register, period counter, envelope, length counter)
// and its update for one item, taken into the registers when step is high.
// ----------------------------------------------------------------------------
module nclfsr_core
  import nclfsr_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  func_t           func,
  input  logic            len_clocking,
  input  logic [LenW-1:0] length_value,
  input  cfg_t            cfg,
  output result_t         res
);

  logic [SrW-1:0]     shift_r,   shift_nxt;
  logic [PeriodW-1:0] period_r,  period_nxt;
  logic [LenW-1:0]    len_r,     len_nxt;
  logic               pend_r,    pend_nxt;
  logic [LenW-1:0]    amount_r,  amount_nxt;
  logic               halt_r,    halt_nxt;
  logic               restart_r, restart_nxt;
  logic [LevelW-1:0]  level_r,   level_nxt;
  logic [DivW-1:0]    div_r,     div_nxt;
  logic [LevelW-1:0]  vol_r,     vol_nxt;
  logic [LevelW-1:0]  out_r,     out_nxt;
  logic               strobe;
  logic               fb;
  logic               pend_eff;

  always_comb begin
    shift_nxt   = shift_r;
    period_nxt  = period_r;
    len_nxt     = len_r;
    pend_nxt    = pend_r;
    amount_nxt  = amount_r;
    halt_nxt    = halt_r;
    restart_nxt = restart_r;
    level_nxt   = level_r;
    div_nxt     = div_r;
    vol_nxt     = vol_r;
    out_nxt     = out_r;
    strobe      = 1'b0;
    fb          = 1'b0;
    pend_eff    = pend_r;

    unique case (func)
      FUNC_TICK: begin
        halt_nxt = cfg.halt_request;
        // length clock in the same cycle wins over a pending reload if length is nonzero
        if (len_clocking && (len_r != '0)) pend_eff = 1'b0;
        if (pend_eff && cfg.channel_enabled) len_nxt = amount_r;
        pend_nxt = 1'b0;
        if (period_r <= PeriodW'(1)) begin
          period_nxt = cfg.timer_period;
          fb = shift_r[0] ^ (cfg.short_mode ? shift_r[6] : shift_r[1]);
          shift_nxt = {fb, shift_r[SrW-1:1] & FbKeep};
          out_nxt = ((len_nxt != '0) && !shift_nxt[0]) ? vol_r : '0;
          strobe = 1'b1;
        end else begin
          period_nxt = period_r - PeriodW'(1);
        end
      end
      FUNC_ENV_CLK: begin
        if (restart_r) begin
          restart_nxt = 1'b0;
          level_nxt   = LevelMax;
          div_nxt     = DivW'(cfg.volume_or_decay);
        end else if (div_r != '0) begin
          div_nxt = div_r - DivW'(1);
        end else begin
          div_nxt = DivW'(cfg.volume_or_decay);
          if (level_r != '0) level_nxt = level_r - LevelW'(1);
          else if (halt_r)   level_nxt = LevelMax;
        end
        vol_nxt = cfg.constant_volume ? cfg.volume_or_decay : level_nxt;
      end
      FUNC_LEN_CLK: begin
        if (!halt_r && (len_r != '0)) len_nxt = len_r - LenW'(1);
      end
      FUNC_LEN_LOAD: begin
        amount_nxt  = length_value;
        pend_nxt    = 1'b1;
        restart_nxt = 1'b1;
      end
      default: ;
    endcase

    res.sample        = out_nxt;
    res.sample_strobe = strobe;
    res.length_active = (len_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r   <= SrReset;
      period_r  <= '0;
      len_r     <= '0;
      pend_r    <= 1'b0;
      amount_r  <= '0;
      halt_r    <= 1'b0;
      restart_r <= 1'b0;
      level_r   <= '0;
      div_r     <= '0;
      vol_r     <= '0;
      out_r     <= '0;
    end else if (step) begin
      shift_r   <= shift_nxt;
      period_r  <= period_nxt;
      len_r     <= len_nxt;
      pend_r    <= pend_nxt;
      amount_r  <= amount_nxt;
      halt_r    <= halt_nxt;
      restart_r <= restart_nxt;
      level_r   <= level_nxt;
      div_r     <= div_nxt;
      vol_r     <= vol_nxt;
      out_r     <= out_nxt;
    end
  end

endmodule

FILE: src/noise_channel_lfsr_envelope_unit.sv
// ----------------------------------------------------------------------------
// noise_channel_lfsr_envelope_unit
// Noise voice: 15-bit feedback shift register with long/short taps, period
// down-counter, decaying envelope and length counter, one result per beat.
// ----------------------------------------------------------------------------
// pipeline: an input beat goes into the input register, then the state update
//   lands in the result register
// throughput: one beat per cycle while out_tready allows; the state update is
//   one pass through the core logic, so each beat sees the prior beat's state
// reset: rst_n synchronous, active low; clears both pipeline registers, the
//   voice state (shift register to 1) and the config (timer_period to 4)
module noise_channel_lfsr_envelope_unit
  import nclfsr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [0] clocking_duration, [8:1] length_value
  input  logic [1:0]          in_tuser,   // [1:0] func
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [3:0] sample, [4] sample_strobe,
                                          // [5] length_active
  // config write port
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t cfg;

  // input register
  logic            in_valid_r;
  func_t           func_r;
  logic            clocking_r;
  logic [LenW-1:0] lval_r;

  // result register
  logic    out_valid_r;
  result_t res_r;
  result_t res;

  logic advance;

  // the item in the input register moves on whenever the result slot is
  // free or is being emptied this cycle
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  // take a new beat when the input register is empty or moving on
  assign in_tready = !in_valid_r || advance;

  nclfsr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  nclfsr_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .func         (func_r),
    .len_clocking (clocking_r),
    .length_value (lval_r),
    .cfg          (cfg),
    .res          (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      func_r     <= FUNC_TICK;
      clocking_r <= 1'b0;
      lval_r     <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
        if (in_tvalid) begin
          func_r     <= func_t'(in_tuser);
          clocking_r <= in_tdata[0];
          lval_r     <= in_tdata[LenW:1];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        res_r       <= res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.length_active, res_r.sample_strobe, res_r.sample};

endmodule

FILE: dv/noise_channel_lfsr_envelope_checker.sv
// ----------------------------------------------------------------------------
// noise_channel_lfsr_envelope_checker
// Watches the input, result and config ports of the noise voice. It keeps its
// own copy of the voice state and registers, works out the result each input
// beat must produce, and compares the result beats in order against it.
// ----------------------------------------------------------------------------
module noise_channel_lfsr_envelope_checker
  import nclfsr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [0] clocking_duration, [8:1] length_value
  input  logic [1:0]          in_tuser,   // [1:0] func
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,  // [3:0] sample, [4] sample_strobe,
                                          // [5] length_active
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int unsigned         n_pending,
  output int unsigned         n_errors
);

  typedef struct {
    logic [SrW-1:0]     lfsr;
    logic [PeriodW-1:0] period_cnt;
    logic [LenW-1:0]    len_cnt;
    logic               reload_pend;
    logic [LenW-1:0]    reload_len;
    logic               halt_q;
    logic               env_restart;
    logic [LevelW-1:0]  env_level;
    logic [DivW-1:0]    env_div;
    logic [LevelW-1:0]  env_vol;
    logic [LevelW-1:0]  level;
  } voice_t;

  voice_t      voice;
  cfg_t        regs;
  result_t     sample_q[$];
  int unsigned mismatches;

  // one beat of the voice: updates the state copy, returns the result it shows
  function automatic result_t advance_voice(func_t kind, logic clk_len,
                                            logic [LenW-1:0] len_val);
    result_t r;
    logic    fb;
    r = '0;
    case (kind)
      FUNC_TICK: begin
        voice.halt_q = regs.halt_request;
        // length clocked in the same cycle wins over a pending reload if length is nonzero
        if (clk_len && voice.len_cnt != '0) voice.reload_pend = 1'b0;
        if (voice.reload_pend) begin
          if (regs.channel_enabled) voice.len_cnt = voice.reload_len;
          voice.reload_pend = 1'b0;
        end
        // a period of 0 behaves like 1
        if (voice.period_cnt <= 1) begin
          voice.period_cnt = regs.timer_period;
          fb = voice.lfsr[0] ^ (regs.short_mode ? voice.lfsr[6] : voice.lfsr[1]);
          voice.lfsr = {fb, voice.lfsr[SrW-1:1]};
          voice.level = (voice.len_cnt != '0 && !voice.lfsr[0]) ? voice.env_vol : '0;
          r.sample_strobe = 1'b1;
        end else begin
          voice.period_cnt = voice.period_cnt - 1'b1;
        end
      end
      FUNC_ENV_CLK: begin
        if (voice.env_restart) begin
          voice.env_restart = 1'b0;
          voice.env_level   = LevelMax;
          voice.env_div     = {1'b0, regs.volume_or_decay};
        end else if (voice.env_div != '0) begin
          voice.env_div = voice.env_div - 1'b1;
        end else begin
          voice.env_div = {1'b0, regs.volume_or_decay};
          if (voice.env_level != '0) voice.env_level = voice.env_level - 1'b1;
          else if (voice.halt_q) voice.env_level = LevelMax;
        end
        voice.env_vol = regs.constant_volume ? regs.volume_or_decay : voice.env_level;
      end
      FUNC_LEN_CLK: begin
        if (!voice.halt_q && voice.len_cnt != '0) voice.len_cnt = voice.len_cnt - 1'b1;
      end
      default: begin
        voice.reload_len  = len_val;
        voice.reload_pend = 1'b1;
        voice.env_restart = 1'b1;
      end
    endcase
    r.sample        = voice.level;
    r.length_active = (voice.len_cnt != '0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      voice = '{lfsr: SrReset, default: '0};
      regs  = '0;
      regs.timer_period = PeriodReset;
      sample_q.delete();
    end else begin
      // the bench must write only while the voice is idle; this checker does not enforce it
      if (cfg_we) begin
        case (cfg_addr)
          REG_SHORT_MODE:      regs.short_mode      = cfg_wdata[0];
          REG_TIMER_PERIOD:    regs.timer_period    = cfg_wdata[PeriodW-1:0];
          REG_HALT_REQUEST:    regs.halt_request    = cfg_wdata[0];
          REG_CONSTANT_VOLUME: regs.constant_volume = cfg_wdata[0];
          REG_VOLUME_OR_DECAY: regs.volume_or_decay = cfg_wdata[LevelW-1:0];
          REG_CHANNEL_ENABLED: regs.channel_enabled = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        sample_q.push_back(advance_voice(func_t'(in_tuser), in_tdata[0], in_tdata[8:1]));
      if (out_tvalid && out_tready) begin
        if (sample_q.size() == 0) begin
          $error("result beat with no expected result: tdata %0h", out_tdata);
          mismatches++;
        end else begin
          want = sample_q.pop_front();
          if (out_tdata[3:0] !== want.sample) begin
            $error("sample mismatch: expected %0d, got %0d", want.sample, out_tdata[3:0]);
            mismatches++;
          end
          if (out_tdata[4] !== want.sample_strobe) begin
            $error("sample_strobe mismatch: expected %0d, got %0d",
                   want.sample_strobe, out_tdata[4]);
            mismatches++;
          end
          if (out_tdata[5] !== want.length_active) begin
            $error("length_active mismatch: expected %0d, got %0d",
                   want.length_active, out_tdata[5]);
            mismatches++;
          end
        end
      end
    end
    n_pending <= sample_q.size();
    n_errors  <= mismatches;
  end

endmodule

FILE: dv/noise_channel_lfsr_envelope_unit_tb.sv
// ----------------------------------------------------------------------------
// noise_channel_lfsr_envelope_unit_tb
// Drives the noise voice with a short directed run of beats and then phases of
// random beats under changing register settings, with random gaps on the input
// and random stalls on the result side. A checker beside the block predicts
// and compares every result beat; this top gives the verdict.
// ----------------------------------------------------------------------------
module noise_channel_lfsr_envelope_unit_tb;
  import nclfsr_pkg::*;

  localparam int unsigned LatencyCycles = 2;
  localparam int unsigned StallLimit    = 1000;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned PhaseBeats    = 105;
  // indexes past the last register, writes there must be ignored
  localparam logic [CfgAddrW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgAddrW-1:0] RegSpareHi = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;   // [0] clocking_duration, [8:1] length_value
  logic [1:0]          in_tuser;   // [1:0] func
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;  // [3:0] sample, [4] sample_strobe, [5] length_active
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  int unsigned n_pending;
  int unsigned n_errors;
  int unsigned quiet_cycles = 0;
  int unsigned rdy_wait;
  // "calm" stretches run without any gaps or stalls
  bit          in_calm  = 1'b0;
  bit          out_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  noise_channel_lfsr_envelope_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  noise_channel_lfsr_envelope_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .n_pending  (n_pending),
    .n_errors   (n_errors)
  );

  // result side: after each taken beat, draw a random wait w and hold tready low until it counts down
  always @(posedge clk) begin : result_sink
    int unsigned w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rdy_wait   <= 0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
        w = out_calm ? 0 : $urandom_range(0, 8);
        if (w != 0) begin
          out_tready <= 1'b0;
          rdy_wait   <= w;
        end
      end
    end else if (rdy_wait <= 1) begin
      out_tready <= 1'b1;
    end else begin
      rdy_wait <= rdy_wait - 1;
    end
  end

  // watchdog: cycles in a row with no beat and no register write
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input beat after a random gap, returns once it is taken
  task automatic send_beat(input func_t kind, input logic clk_len,
                           input logic [LenW-1:0] len_val);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, len_val, clk_len};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop sending and let every outstanding result drain
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (LatencyCycles + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned       roll;
    func_t             kind;
    logic [PeriodW-1:0] period;
    logic [LevelW-1:0] vod;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = FUNC_TICK;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: step every tick, slow decay, channel on
    write_reg(REG_SHORT_MODE, 12'd0);
    write_reg(REG_TIMER_PERIOD, 12'd1);
    write_reg(REG_HALT_REQUEST, 12'd0);
    write_reg(REG_CONSTANT_VOLUME, 12'd0);
    write_reg(REG_VOLUME_OR_DECAY, 12'd2);
    write_reg(REG_CHANNEL_ENABLED, 12'hFFF);
    write_reg(RegSpareLo, 12'hFFF);
    write_reg(RegSpareHi, 12'hA5A);

    send_beat(FUNC_TICK, 1'b0, 8'd0);        // nothing loaded yet, level stays 0
    send_beat(FUNC_LEN_LOAD, 1'b0, 8'd0);    // reload of zero
    send_beat(FUNC_TICK, 1'b0, 8'd0);
    send_beat(FUNC_LEN_LOAD, 1'b1, 8'd254);  // longest reload this bench uses
    send_beat(FUNC_ENV_CLK, 1'b0, 8'd0);     // envelope restart to full
    send_beat(FUNC_TICK, 1'b1, 8'd0);        // length zero: clocking does not cancel
    send_beat(FUNC_TICK, 1'b0, 8'd0);
    send_beat(FUNC_TICK, 1'b1, 8'd0);
    send_beat(FUNC_ENV_CLK, 1'b0, 8'd0);
    send_beat(FUNC_ENV_CLK, 1'b0, 8'd0);
    send_beat(FUNC_ENV_CLK, 1'b0, 8'd0);     // divider ran out, level drops
    send_beat(FUNC_LEN_CLK, 1'b0, 8'd0);
    send_beat(FUNC_LEN_LOAD, 1'b0, 8'd1);
    send_beat(FUNC_TICK, 1'b1, 8'd0);        // length nonzero: reload cancelled
    send_beat(FUNC_LEN_LOAD, 1'b0, 8'd1);
    send_beat(FUNC_TICK, 1'b0, 8'd0);        // loads 1
    send_beat(FUNC_LEN_CLK, 1'b0, 8'd0);     // down to zero
    send_beat(FUNC_LEN_CLK, 1'b1, 8'd0);     // stays at zero
    send_beat(FUNC_TICK, 1'b0, 8'd0);
    send_beat(FUNC_LEN_LOAD, 1'b1, 8'h55);
    send_beat(FUNC_TICK, 1'b0, 8'hAA);
    send_beat(FUNC_ENV_CLK, 1'b1, 8'hFE);

    // random phases, each with its own register setting
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        2:       period = 12'd0;     // zero period steps on every tick
        5:       period = 12'd4095;
        7:       period = 12'd1;
        default: period = 12'($urandom_range(1, 6));
      endcase
      case (p)
        0:       vod = 4'd0;
        3:       vod = 4'd15;
        default: vod = 4'($urandom_range(0, 15));
      endcase
      // upper bits above the one-bit and four-bit registers carry junk
      write_reg(REG_SHORT_MODE, {11'($urandom), p[0]});
      write_reg(REG_TIMER_PERIOD, period);
      write_reg(REG_HALT_REQUEST, {11'($urandom), p[1]});
      write_reg(REG_CONSTANT_VOLUME, {11'($urandom), p[2]});
      write_reg(REG_VOLUME_OR_DECAY, {8'($urandom), vod});
      write_reg(REG_CHANNEL_ENABLED, {11'($urandom), p != 4});
      repeat (PhaseBeats) begin
        roll = $urandom_range(0, 99);
        kind = roll < 55 ? FUNC_TICK :
               roll < 70 ? FUNC_ENV_CLK :
               roll < 85 ? FUNC_LEN_CLK : FUNC_LEN_LOAD;
        send_beat(kind, $urandom_range(0, 3) == 0, 8'($urandom_range(0, 254)));
      end
    end

    settle();
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
